// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the console writer RTL.
// Each macro declares one labeled concurrent assertion on a clock and an
// active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer: screen geometry,
// control characters, payload structs and the internal command format.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS + 8);
    localparam int ROW_W   = $clog2(ROWS + 1);

    // Command queue between the front and back parts.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    // Character codes and reset attribute.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } t_out_item;

    // Memory work handed from the front part to the back part.
    typedef enum logic [1:0] {
        BOP_NONE  = 2'd0,
        BOP_WRITE = 2'd1,
        BOP_CLEAR = 2'd2,
        BOP_READ  = 2'd3
    } t_back_op;

    typedef struct packed {
        t_back_op          op;
        logic              scroll;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        ch;
        logic [4:0]        row;
        logic [6:0]        col;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE  = 2'd0,
        BS_SWEEP = 2'd1,
        BS_READ  = 2'd2
    } t_back_state;

    typedef struct packed {
        logic busy;
        logic take;
    } t_back_stat;

endpackage

// ----- hw/rtl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read of the address being written returns old data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front
// Front part: accepts operations, tracks the cursor and turns each
// operation into one memory command plus its cursor result.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_cmd     o_cmd
);

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;

    // Decode the operation and compute the next cursor.
    always_comb begin
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] wr_col;
        logic [COL_W-1:0] tab_col;
        logic             we;
        logic             scroll;
        logic [7:0]       wch;

        col     = r_col;
        row     = r_row;
        wr_col  = r_col;
        tab_col = r_col + COL_W'(8);
        we      = 1'b0;
        scroll  = 1'b0;
        wch     = i_item.char_code;
        o_cmd   = '0;
        o_cmd.op = BOP_NONE;

        unique case (i_item.opcode)
            OP_PUT: begin
                priority if (i_item.char_code == CH_NEWLINE) begin
                    col = '0;
                    row = r_row + ROW_W'(1);
                end else if (i_item.char_code == CH_BACKSPACE) begin
                    if (r_col != '0) begin
                        col = r_col - COL_W'(1);
                    end
                    wr_col = col;
                    we     = 1'b1;
                    wch    = BLANK_CHAR;
                end else if (i_item.char_code == CH_RETURN) begin
                    col = '0;
                end else if (i_item.char_code == CH_TAB) begin
                    col = {tab_col[COL_W-1:3], 3'b000};
                end else begin
                    we  = 1'b1;
                    col = r_col + COL_W'(1);
                end
                // Wrap at the right edge, scroll past the bottom row.
                if (col >= COL_W'(COLUMNS)) begin
                    col = '0;
                    row = row + ROW_W'(1);
                end
                if (row >= ROW_W'(ROWS)) begin
                    scroll = 1'b1;
                    row    = ROW_W'(ROWS - 1);
                    col    = '0;
                end
                o_cmd.op     = we ? BOP_WRITE : BOP_NONE;
                o_cmd.scroll = scroll;
                o_cmd.addr   = ADDR_W'(32'(r_row) * COLUMNS + 32'(wr_col));
                o_cmd.ch     = wch;
            end
            OP_CLEAR: begin
                row      = '0;
                col      = '0;
                o_cmd.op = BOP_CLEAR;
            end
            OP_READ: begin
                // Out-of-range indexes read zero without touching memory.
                if ({21'd0, i_item.cell_index} < 32'(CELLS)) begin
                    o_cmd.op = BOP_READ;
                end
                o_cmd.addr = ADDR_W'(i_item.cell_index);
            end
            OP_NONE: begin
                o_cmd.op = BOP_NONE;
            end
            default: begin
                o_cmd.op = BOP_NONE;
            end
        endcase

        o_cmd.row = 5'(row);
        o_cmd.col = 7'(col);
        n_row = row;
        n_col = col;
    end

    // Cursor registers advance on each accepted operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

// ----- hw/rtl/tcw_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// tcw_cmd_fifo
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module tcw_cmd_fifo import tcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wp;
    logic [CMDQ_PTR_W-1:0] r_rp;
    logic [CMDQ_PTR_W:0]   r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + CMDQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (CMDQ_PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (CMDQ_PTR_W + 1)'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back
// Back part: carries out memory commands on the screen RAM (cell writes,
// scroll copy, clear sweep, cell reads) and holds the result register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_attr,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_empty,
    output logic       o_cmd_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output t_out_item  o_out,
    output t_back_stat o_stat
);

    t_back_state       r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    t_cmd              r_cur, n_cur;
    logic              r_wr_vld, n_wr_vld;
    logic              r_wr_copy, n_wr_copy;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic [15:0]       r_wr_data, n_wr_data;
    logic              r_res_vld, n_res_vld;
    t_out_item         r_res, n_res;

    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;
    logic [15:0]       ram_wdata;
    logic [15:0]       blank;
    logic              slot_free;

    assign blank     = {i_attr, BLANK_CHAR};
    assign slot_free = !r_res_vld || i_pop;
    assign ram_wdata = r_wr_copy ? ram_rdata : r_wr_data;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (r_wr_vld),
        .i_waddr (r_wr_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Command sequencer: next state, RAM control and result loading.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_cur     = r_cur;
        n_wr_vld  = 1'b0;
        n_wr_copy = 1'b0;
        n_wr_addr = r_cnt;
        n_wr_data = blank;
        n_res_vld = r_res_vld && !i_pop;
        n_res     = r_res;
        ram_raddr = i_cmd.addr;
        o_cmd_pop = 1'b0;

        unique case (r_state)
            BS_IDLE: begin
                // A read waits while a cell write is still in flight.
                if (!i_cmd_empty && slot_free &&
                    !(i_cmd.op == BOP_READ && r_wr_vld)) begin
                    o_cmd_pop = 1'b1;
                    n_cur     = i_cmd;
                    n_cnt     = '0;
                    n_res.read_data  = '0;
                    n_res.cursor_row = i_cmd.row;
                    n_res.cursor_col = i_cmd.col;
                    n_res.scrolled   = i_cmd.scroll;
                    unique case (i_cmd.op)
                        BOP_WRITE: begin
                            n_wr_vld  = 1'b1;
                            n_wr_addr = i_cmd.addr;
                            n_wr_data = {i_attr, i_cmd.ch};
                            if (i_cmd.scroll) begin
                                n_state = BS_SWEEP;
                            end else begin
                                n_res_vld = 1'b1;
                            end
                        end
                        BOP_NONE: begin
                            if (i_cmd.scroll) begin
                                n_state = BS_SWEEP;
                            end else begin
                                n_res_vld = 1'b1;
                            end
                        end
                        BOP_CLEAR: begin
                            n_state = BS_SWEEP;
                        end
                        BOP_READ: begin
                            n_state = BS_READ;
                        end
                        default: begin
                            n_state = BS_IDLE;
                        end
                    endcase
                end
            end
            BS_SWEEP: begin
                // One cell a cycle: copy from the row below, or blank.
                n_wr_vld  = 1'b1;
                n_wr_addr = r_cnt;
                n_wr_copy = (r_cur.op != BOP_CLEAR) &&
                            (r_cnt < ADDR_W'(CELLS - COLUMNS));
                ram_raddr = r_cnt + ADDR_W'(COLUMNS);
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_state   = BS_IDLE;
                    n_res_vld = 1'b1;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            BS_READ: begin
                ram_raddr       = r_cur.addr;
                n_res.read_data = ram_rdata;
                n_res_vld       = 1'b1;
                n_state         = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_wr_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_vld  <= n_wr_vld;
            r_res_vld <= n_res_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_cur     <= n_cur;
        r_wr_copy <= n_wr_copy;
        r_wr_addr <= n_wr_addr;
        r_wr_data <= n_wr_data;
        r_res     <= n_res;
    end

    assign o_empty     = !r_res_vld;
    assign o_out       = r_res;
    assign o_stat.busy = (r_state != BS_IDLE);
    assign o_stat.take = o_cmd_pop;

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console: a screen buffer in RAM, a cursor, and
// put / clear / read operations with wrap and scroll.
//
//   Channel   Handshake                 Payload
//   input     push, full                i_in  (t_in_item)
//   result    empty, pop                o_out (t_out_item)
//   config    i_cfg_valid, o_cfg_ready  i_cfg_data (attribute byte)
//
// A put, a nop and an out-of-range read are taken and finished directly
// from idle in the back part; an in-range read passes through a read
// state, and waits first when it directly follows a cell write.
// Scroll and clear take the command, then sweep the COLUMNS*ROWS RAM
// cells, one cell per cycle.
// The front part keeps accepting into a four-entry command queue meanwhile, until it fills.
// Reset is synchronous; the screen RAM is not cleared by reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer import tcw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_in,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_attr;
    logic       in_accept;
    t_cmd       front_cmd;
    t_cmd       cmdq_head;
    logic       cmdq_full;
    logic       cmdq_empty;
    logic       cmdq_pop;
    t_back_stat back_stat;
    logic       res_at_home;

    assign o_cfg_ready = 1'b1;
    assign full        = cmdq_full;
    assign in_accept   = push && !cmdq_full;

    // Attribute register, written by a configuration transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_attr <= i_cfg_data;
        end
    end

    tcw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in),
        .o_cmd    (front_cmd)
    );

    tcw_cmd_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_cmd),
        .o_full  (cmdq_full),
        .i_pop   (cmdq_pop),
        .o_data  (cmdq_head),
        .o_empty (cmdq_empty)
    );

    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_attr),
        .i_cmd       (cmdq_head),
        .i_cmd_empty (cmdq_empty),
        .o_cmd_pop   (cmdq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out),
        .o_stat      (back_stat)
    );

    // A scrolled result leaves the cursor at the start of the bottom row.
    assign res_at_home = (o_out.cursor_row == 5'(ROWS - 1)) && (o_out.cursor_col == 7'd0);

    // Checks on cursor results and on the front/back hand-off.
    `TCW_ASSERT_IMP(a_row_in_range, i_clk, i_rst_n, !empty, o_out.cursor_row < 5'(ROWS))
    `TCW_ASSERT_IMP(a_scroll_homes, i_clk, i_rst_n, !empty && o_out.scrolled, res_at_home)
    `TCW_ASSERT_IMP(a_busy_no_take, i_clk, i_rst_n, back_stat.busy, !back_stat.take)
    `TCW_ASSERT_NXT(a_queue_filled, i_clk, i_rst_n, push && !full, !cmdq_empty)

endmodule

// ----- verif/text_console_writer_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A queue-fed driver offers
// put, clear, read and no-op commands, and a shadow copy of the screen and
// cursor predicts each result. A monitor compares every result transfer
// against the oldest prediction, field by field. The attribute register is
// rewritten between phases while the block is drained. Random idle bursts,
// a long result hold-off and a final idle-free phase vary the timing.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE_CYCLES = CELLS + 100;
    localparam int LONG_HOLD = 400;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_item   i_in = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  o_out;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    // Shadow of the screen buffer, cursor and attribute register.
    logic [15:0] shadow_cells [CELLS];
    int          cur_row = 0;
    int          cur_col = 0;
    logic [7:0]  shadow_attr = ATTR_RESET;

    t_in_item  cmd_q [$];
    t_out_item result_q [$];
    int        fail_count = 0;
    int        quiet_cycles = 0;
    bit        tx_idle_en = 1'b0;
    bit        rx_idle_en = 1'b0;
    int        long_hold_seq = 0;

    text_console_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Apply one command to the shadow console and return the result it gives.
    function automatic t_out_item console_apply(input t_in_item cmd);
        t_out_item   res;
        logic [15:0] blank;
        res = '0;
        blank = {shadow_attr, BLANK_CHAR};
        case (cmd.opcode)
            OP_PUT: begin
                case (cmd.char_code)
                    CH_NEWLINE: begin
                        cur_col = 0;
                        cur_row++;
                    end
                    CH_BACKSPACE: begin
                        if (cur_col > 0) cur_col--;
                        shadow_cells[cur_row * COLUMNS + cur_col] = blank;
                    end
                    CH_RETURN: cur_col = 0;
                    CH_TAB: cur_col = (cur_col + 8) & ~7;
                    default: begin
                        shadow_cells[cur_row * COLUMNS + cur_col] =
                            {shadow_attr, cmd.char_code};
                        cur_col++;
                    end
                endcase
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // Running off the bottom shifts every row up and blanks the last one.
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELLS; i++) begin
                        shadow_cells[i] = (i < CELLS - COLUMNS) ?
                            shadow_cells[i + COLUMNS] : blank;
                    end
                    cur_row = ROWS - 1;
                    cur_col = 0;
                    res.scrolled = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) shadow_cells[i] = blank;
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ: begin
                if (cmd.cell_index < CELLS) res.read_data = shadow_cells[cmd.cell_index];
            end
            default: ;
        endcase
        res.cursor_row = cur_row[4:0];
        res.cursor_col = cur_col[6:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Command driver: one queued command per transfer, with random gaps.
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            gap_left = 0;
        end else if (!(push && full)) begin
            if (push && tx_idle_en && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 9);
            if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                i_in <= cmd_q.pop_front();
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts and one long hold-off.
    int stall_left = 0;
    int long_hold_seen = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
        end else begin
            if (long_hold_seq != long_hold_seen) begin
                long_hold_seen = long_hold_seq;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Monitor: predict on each command transfer, check each result transfer.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) shadow_attr = i_cfg_data;
            if (push && !full) result_q.push_back(console_apply(i_in));
            if (pop && !empty) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result transfer with none expected, actual 0x%0h",
                             $time, o_out);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("read_data", want.read_data, o_out.read_data);
                    check_field("cursor_row", 16'(want.cursor_row), 16'(o_out.cursor_row));
                    check_field("cursor_col", 16'(want.cursor_col), 16'(o_out.cursor_col));
                    check_field("scrolled", 16'(want.scrolled), 16'(o_out.scrolled));
                end
            end
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    function automatic void queue_cmd(input t_opcode op, input logic [7:0] ch,
                                      input logic [10:0] idx);
        t_in_item it;
        it.opcode = op;
        it.char_code = ch;
        it.cell_index = idx;
        cmd_q.push_back(it);
    endfunction

    // One random command, weighted toward puts and reads.
    function automatic t_in_item random_cmd();
        t_in_item it;
        int       pick;
        it.char_code = 8'($urandom_range(0, 255));
        it.cell_index = 11'($urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.opcode = OP_PUT;
        end else if (pick < 70) begin
            it.opcode = OP_PUT;
            case ($urandom_range(0, 3))
                0: it.char_code = CH_NEWLINE;
                1: it.char_code = CH_BACKSPACE;
                2: it.char_code = CH_RETURN;
                default: it.char_code = CH_TAB;
            endcase
        end else if (pick < 90) begin
            it.opcode = OP_READ;
            if ($urandom_range(0, 9) != 0) it.cell_index = 11'($urandom_range(0, CELLS - 1));
        end else if (pick < 93) begin
            it.opcode = OP_CLEAR;
        end else begin
            it.opcode = OP_NONE;
        end
        return it;
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || push || result_q.size() != 0);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random phase: mostly single commands, with occasional newline runs
    // that push the cursor toward the bottom row and can force scrolling.
    task automatic random_phase(input int count, input bit idle_en, input bit long_hold);
        int       done;
        int       run;
        t_in_item it;
        @(negedge i_clk);
        tx_idle_en = idle_en;
        rx_idle_en = idle_en;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 59) == 0) begin
                run = $urandom_range(2, 20);
                repeat (run) queue_cmd(OP_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
                done += run;
            end else begin
                it = random_cmd();
                cmd_q.push_back(it);
                done++;
            end
        end
        if (long_hold) long_hold_seq++;
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset attribute. Only cell 0 is written before
        // the clear, so reads before it stay on that cell or out of range.
        @(negedge i_clk);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        queue_cmd(OP_PUT, 8'h41, 11'h000);
        queue_cmd(OP_READ, 8'h00, 11'h000);
        queue_cmd(OP_READ, 8'h00, 11'(CELLS));
        queue_cmd(OP_READ, 8'hFF, 11'h7FF);
        queue_cmd(OP_NONE, 8'hFF, 11'h7FF);
        queue_cmd(OP_CLEAR, 8'h00, 11'h000);
        queue_cmd(OP_PUT, CH_BACKSPACE, 11'h000);
        queue_cmd(OP_PUT, 8'h00, 11'h000);
        queue_cmd(OP_PUT, 8'hFF, 11'h7FF);
        queue_cmd(OP_PUT, CH_BACKSPACE, 11'h000);
        queue_cmd(OP_PUT, CH_TAB, 11'h000);
        queue_cmd(OP_PUT, CH_RETURN, 11'h000);
        queue_cmd(OP_PUT, CH_NEWLINE, 11'h000);
        queue_cmd(OP_READ, 8'h00, 11'h000);
        queue_cmd(OP_READ, 8'h00, 11'(CELLS - 1));
        // Ten tabs run the cursor off the end of the line.
        repeat (10) queue_cmd(OP_PUT, CH_TAB, 11'h000);
        wait_drained();

        write_attribute(8'h00);
        random_phase(200, 1'b1, 1'b0);
        write_attribute(8'hFF);
        random_phase(200, 1'b1, 1'b1);
        write_attribute(8'($urandom_range(0, 255)));
        random_phase(200, 1'b1, 1'b0);
        write_attribute(8'($urandom_range(0, 255)));
        random_phase(225, 1'b0, 1'b0);

        // Let any trailing sweep finish so a stray result would still be seen.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, result_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- text_console_writer.f -----
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_cmd_fifo.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer.sv
verif/text_console_writer_tb.sv
